@@ rtl/key_hash_index_table_assert.svh @@
// Assertion macros shared by the key hash index table RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef KEY_HASH_INDEX_TABLE_ASSERT_SVH
`define KEY_HASH_INDEX_TABLE_ASSERT_SVH

// The expression must hold at every clock edge out of reset.
`define KHIT_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("key hash index table: invariant violated");

// The consequent must hold in the cycle after the antecedent.
`define KHIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("key hash index table: sequence violated");

`endif

@@ rtl/khit_pkg.sv @@
`timescale 1ns / 1ps

package khit_pkg;

    localparam int HASH_W = 24;
    localparam int SLOT_W = 8;

    // Slot index that marks an invalid pair; find never matches it and returns it on a miss.
    localparam logic [SLOT_W-1:0] SLOT_INVALID = 8'hff;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [HASH_W-1:0] hash;
    } t_entry;

    typedef struct packed {
        t_action           action;
        logic [HASH_W-1:0] key_hash;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] found_index;
    } t_result;

endpackage

@@ rtl/key_hash_index_table.sv @@
`timescale 1ns / 1ps
// Key hash index table: an ordered list of up to ENTRIES (hash, slot) pairs.
// Requests arrive on the s-side stream (i_s_tvalid, o_s_tready, i_s_tdata); each
// request gives exactly one result on the m-side stream (o_m_*).
// Append and clear go from acceptance straight to the done state.
// Find walks the list from the front through one memory read port and one
// compare unit, one entry per cycle, and stops at the first hit or at the end.
// Erase searches the same way and then moves every later pair down one place,
// one pair per cycle over the same port.
// The block takes one request at a time; o_s_tready is high only while idle.
// The result is held in an output register, so the next request is taken while
// a finished result still waits for i_m_tready; a stalled receiver stops the
// block only when a second result is ready to leave.
// A synchronous reset (i_rst_n low) empties the list and drops a pending result.
// Pair storage is not cleared; only entries below the fill count are read.

module key_hash_index_table #(
    parameter int ENTRIES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0: action[1:0], key_hash[25:2], slot_index[33:26], zero pad.
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0: status[1:0], found_index[9:2], zero pad.
    output logic [15:0] o_m_tdata
);

    khit_pkg::t_req    req;
    khit_pkg::t_result core_res;
    logic              core_res_valid;
    logic              core_res_ready;

    logic              r_out_vld;
    khit_pkg::t_result r_out_res;

    // Unpack the request fields.
    assign req.action     = khit_pkg::t_action'(i_s_tdata[1:0]);
    assign req.key_hash   = i_s_tdata[25:2];
    assign req.slot_index = i_s_tdata[33:26];

    khit_core #(
        .ENTRIES(ENTRIES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (core_res_valid),
        .i_res_ready (core_res_ready),
        .o_res       (core_res)
    );

    // Output register: free when empty or being drained this cycle.
    assign core_res_ready = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (core_res_valid && core_res_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_res_valid && core_res_ready) begin
            r_out_res <= core_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'b0, r_out_res.found_index, r_out_res.status};

endmodule

@@ rtl/khit_core.sv @@
`timescale 1ns / 1ps

module khit_core #(
    parameter int ENTRIES = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  khit_pkg::t_req    i_req,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output khit_pkg::t_result o_res
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // Pair storage, one read and one write port.
    khit_pkg::t_entry r_mem [ENTRIES];

    khit_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_dst, n_dst;
    khit_pkg::t_req    r_req, n_req;
    khit_pkg::t_result r_res, n_res;

    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_idx;
    khit_pkg::t_entry  r_rdata;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    khit_pkg::t_entry  wr_data;
    logic              find_hit;
    logic              erase_hit;
    logic              hit;
    logic              req_acc;

    // Compare the entry that came back from the memory with the request.
    assign find_hit = (r_rdata.slot >= r_req.slot_index) &&
                      (r_rdata.slot != khit_pkg::SLOT_INVALID) &&
                      (r_rdata.hash == r_req.key_hash);
    assign erase_hit = (r_rdata.slot == r_req.slot_index);
    assign hit = r_rd_vld &&
                 ((r_req.action == khit_pkg::ACT_ERASE) ? erase_hit : find_hit);

    assign req_acc = i_req_valid && o_req_ready;

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        r_rd_idx <= rd_addr;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= khit_pkg::S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= rd_en;
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_dst <= n_dst;
        r_req <= n_req;
        r_res <= n_res;
    end

    // Sequencer: next state, memory port control and the result.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_dst       = r_dst;
        n_req       = r_req;
        n_res       = r_res;
        rd_en       = 1'b0;
        rd_addr     = r_ptr[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = '{slot: i_req.slot_index, hash: i_req.key_hash};
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            khit_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_req = i_req;
                    n_ptr = '0;
                    n_res = '{status: khit_pkg::ST_OK, found_index: khit_pkg::SLOT_INVALID};
                    case (i_req.action)
                        khit_pkg::ACT_APPEND: begin
                            n_state = khit_pkg::S_DONE;
                            if (r_count >= CW'(ENTRIES)) begin
                                n_res.status = khit_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        khit_pkg::ACT_CLEAR: begin
                            n_state = khit_pkg::S_DONE;
                            n_count = '0;
                        end
                        default: begin
                            n_state = khit_pkg::S_SCAN;
                        end
                    endcase
                end
            end

            khit_pkg::S_SCAN: begin
                // One read issued per cycle; the compare uses the data in the cycle after the read.
                rd_en = (r_ptr < r_count);
                if (rd_en) begin
                    n_ptr = r_ptr + 1'b1;
                end
                if (hit) begin
                    if (r_req.action == khit_pkg::ACT_ERASE) begin
                        n_dst   = r_rd_idx;
                        n_state = khit_pkg::S_SHIFT;
                    end else begin
                        n_res   = '{status: khit_pkg::ST_OK, found_index: r_rdata.slot};
                        n_state = khit_pkg::S_DONE;
                    end
                end else if (!r_rd_vld && !rd_en) begin
                    n_res   = '{status: khit_pkg::ST_NOT_FOUND,
                                found_index: khit_pkg::SLOT_INVALID};
                    n_state = khit_pkg::S_DONE;
                end
            end

            khit_pkg::S_SHIFT: begin
                // Move every later pair down one place, one per cycle.
                rd_en = (r_ptr < r_count);
                if (rd_en) begin
                    n_ptr = r_ptr + 1'b1;
                end
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_dst;
                    wr_data = r_rdata;
                    n_dst   = AW'(r_dst + 1'b1);
                end else if (!rd_en) begin
                    n_count = r_count - 1'b1;
                    n_res   = '{status: khit_pkg::ST_OK, found_index: khit_pkg::SLOT_INVALID};
                    n_state = khit_pkg::S_DONE;
                end
            end

            khit_pkg::S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = khit_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = khit_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

`include "key_hash_index_table_assert.svh"

    // The fill count never passes the capacity.
    `KHIT_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(ENTRIES))
    // The memory is written only by an append request or the shift pass.
    `KHIT_ASSERT_ALWAYS(a_write_src, !wr_en || (r_state == khit_pkg::S_SHIFT) || req_acc)
    // The shift pass writes only inside the live part of the list.
    `KHIT_ASSERT_ALWAYS(a_shift_dst, (r_state != khit_pkg::S_SHIFT) || (CW'(r_dst) < r_count))
    // A clear request empties the list.
    `KHIT_ASSERT_NEXT(a_clear, req_acc && (i_req.action == khit_pkg::ACT_CLEAR), r_count == '0)

endmodule
